/* hdl/mtdc_pkg.sv */
// ----------------------------------------------------------------------------
// mtdc_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// multi-tap delay chorus core.
// ----------------------------------------------------------------------------
package mtdc_pkg;

   // fixed field widths
   localparam int SAMPLE_W     = 16;
   localparam int LEN_REG_W    = 13;
   localparam int VOICE_REG_W  = 5;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 4;

   // register reset values
   localparam int RESET_LENGTH = 4096;
   localparam int RESET_VOICES = 1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_LENGTH  = 4'd0,
      CSR_VOICE_COUNT  = 4'd1
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic write_mem;
      logic tap_init;
      logic tap_issue;
      logic step_zero;
      logic step_load;
      logic div_start;
      logic div_avg;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic out_free;
      logic one_voice;
      logic tap_last;
   } dp_status_type;

endpackage

/* hdl/mtdc_if.sv */
// ----------------------------------------------------------------------------
// mtdc_req_if / mtdc_rsp_if
// Valid/ready stream channels carrying one audio sample per item.
// ----------------------------------------------------------------------------
interface mtdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface mtdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* hdl/mtdc_ram.sv */
// ----------------------------------------------------------------------------
// mtdc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mtdc_divider.sv */
// ----------------------------------------------------------------------------
// mtdc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtdc_divider #(
   parameter int DIVIDEND_W = 21,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge    = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
         rem_ff <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hdl/mtdc_datapath.sv */
// ----------------------------------------------------------------------------
// mtdc_datapath
// Configuration registers, delay line, tap walker, accumulator, shared
// divider and output register.
// ----------------------------------------------------------------------------
module mtdc_datapath import mtdc_pkg::*; #(
   parameter int DELAY_DEPTH = 4096,
   parameter int MAX_VOICES  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [SAMPLE_W-1:0]    sample_in,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic [SAMPLE_W-1:0]    sample_out,
   output logic                   out_valid,
   input  logic                   out_ready
);

   localparam int ADDR_W    = $clog2(DELAY_DEPTH);
   localparam int LEN_W     = $clog2(DELAY_DEPTH + 1);
   localparam int VC_W      = $clog2(MAX_VOICES + 1);
   localparam int K_W       = $clog2(MAX_VOICES);
   localparam int SUM_W     = SAMPLE_W + $clog2(MAX_VOICES) + 1;
   localparam int DIV_W     = (SUM_W > LEN_W) ? SUM_W : LEN_W;
   localparam int LCMP_W    = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
   localparam int VCMP_W    = (VC_W > VOICE_REG_W) ? VC_W : VOICE_REG_W;
   localparam int STEP_W    = LEN_W + 1;
   localparam int IDX_W     = LEN_W + 2;
   localparam int RESET_LEN = (RESET_LENGTH > DELAY_DEPTH) ? DELAY_DEPTH : RESET_LENGTH;

   // configuration
   logic [LEN_W-1:0]         len_ff;
   logic [VC_W-1:0]          vc_ff;
   logic [LCMP_W-1:0]        len_raw;
   logic [LCMP_W-1:0]        len_sat;
   logic [VCMP_W-1:0]        vc_raw;
   logic [VCMP_W-1:0]        vc_sat;
   logic                     csr_hit;
   logic [VC_W-1:0]          vc_m1;

   // delay line position
   logic [ADDR_W-1:0]        wp_ff;
   logic [ADDR_W-1:0]        wp_in;
   logic [LEN_W:0]           wp_inc;
   logic                     wrapped_ff;
   logic [SAMPLE_W-1:0]      sample_ff;

   // tap walk
   logic [ADDR_W-1:0]        idx_ff;
   logic [ADDR_W-1:0]        idx_in;
   logic [K_W-1:0]           k_ff;
   logic signed [STEP_W-1:0] step_ff;
   logic signed [IDX_W-1:0]  idx_ext;
   logic signed [IDX_W-1:0]  step_ext;
   logic signed [IDX_W-1:0]  len_ext;
   logic signed [IDX_W-1:0]  idx_diff;
   logic signed [IDX_W-1:0]  idx_wrap;
   logic                     rd_pend_ff;
   logic                     rd_ok_ff;
   logic                     tap_ok;
   logic [SAMPLE_W-1:0]      rd_data;

   // accumulate and divide
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         sum_abs;
   logic                     sum_neg;
   logic [DIV_W-1:0]         div_dividend;
   logic [VC_W-1:0]          div_divisor;
   logic [DIV_W-1:0]         quotient;
   logic                     div_done;
   logic [DIV_W-1:0]         avg;

   // output register
   logic [SAMPLE_W-1:0]      out_data_ff;
   logic                     out_valid_ff;

   // register write saturation
   always_comb begin
      len_raw = LCMP_W'(csr_wdata[LEN_REG_W-1:0]);
      if (len_raw == '0) begin
         len_sat = LCMP_W'(1);
      end else if (len_raw > LCMP_W'(DELAY_DEPTH)) begin
         len_sat = LCMP_W'(DELAY_DEPTH);
      end else begin
         len_sat = len_raw;
      end
      vc_raw = VCMP_W'(csr_wdata[VOICE_REG_W-1:0]);
      if (vc_raw == '0) begin
         vc_sat = VCMP_W'(1);
      end else if (vc_raw > VCMP_W'(MAX_VOICES)) begin
         vc_sat = VCMP_W'(MAX_VOICES);
      end else begin
         vc_sat = vc_raw;
      end
      csr_hit = csr_wr_en && ((csr_index == CSR_LINE_LENGTH) ||
                              (csr_index == CSR_VOICE_COUNT));
      vc_m1   = vc_ff - VC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(RESET_LEN);
         vc_ff  <= VC_W'(RESET_VOICES);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_LENGTH: len_ff <= len_sat[LEN_W-1:0];
            CSR_VOICE_COUNT: vc_ff  <= vc_sat[VC_W-1:0];
            default: ;
         endcase
      end
   end

   // write position advance with wrap at the length
   always_comb begin
      wp_inc = (LEN_W+1)'(wp_ff) + (LEN_W+1)'(1);
      if (wp_inc >= (LEN_W+1)'(len_ff)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_inc[ADDR_W-1:0];
      end
   end

   // position and fill tracking; a clear restarts the fill
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            wp_ff <= wp_in;
         end
         if (cmd.write_mem && (wp_ff == '0)) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample_in;
      end
   end

   // delay store
   mtdc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write_mem),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // next tap index, wrapped once in either direction
   always_comb begin
      idx_ext  = $signed(IDX_W'(idx_ff));
      step_ext = IDX_W'(step_ff);
      len_ext  = $signed(IDX_W'(len_ff));
      idx_diff = idx_ext - step_ext;
      if (idx_diff < 0) begin
         idx_wrap = idx_diff + len_ext;
      end else if (idx_diff >= len_ext) begin
         idx_wrap = idx_diff - len_ext;
      end else begin
         idx_wrap = idx_diff;
      end
      idx_in = idx_wrap[ADDR_W-1:0];
      // entries not written since the last clear read as zero
      tap_ok = wrapped_ff || ((idx_ff != '0) && (idx_ff <= wp_ff));
   end

   // tap walker
   always_ff @(posedge clock) begin
      if (cmd.tap_init) begin
         idx_ff <= wp_ff;
         k_ff   <= '0;
      end else if (cmd.tap_issue) begin
         idx_ff <= idx_in;
         k_ff   <= k_ff + K_W'(1);
      end
      if (cmd.step_zero) begin
         step_ff <= '0;
      end else if (cmd.step_load) begin
         step_ff <= {1'b0, quotient[LEN_W-1:0]} - STEP_W'(1);
      end
      rd_ok_ff <= tap_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.tap_issue;
      end
   end

   // accumulator
   always_ff @(posedge clock) begin
      if (cmd.tap_init) begin
         sum_ff <= '0;
      end else if (rd_pend_ff && rd_ok_ff) begin
         sum_ff <= sum_ff + {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
      end
   end

   // shared divider: length over voices-1, then magnitude of sum over voices
   always_comb begin
      sum_neg      = sum_ff[SUM_W-1];
      sum_abs      = sum_neg ? (SUM_W'(0) - sum_ff) : sum_ff;
      div_dividend = cmd.div_avg ? DIV_W'(sum_abs) : DIV_W'(len_ff);
      div_divisor  = cmd.div_avg ? vc_ff : vc_m1;
      avg          = sum_neg ? (DIV_W'(0) - quotient) : quotient;
   end

   mtdc_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (VC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= avg[SAMPLE_W-1:0];
      end
   end

   // status
   always_comb begin
      status.div_done  = div_done;
      status.out_free  = !out_valid_ff || out_ready;
      status.one_voice = (vc_ff == VC_W'(1));
      status.tap_last  = (VC_W'(k_ff) == vc_m1);
   end

   assign sample_out = out_data_ff;
   assign out_valid  = out_valid_ff;

endmodule

/* hdl/mtdc_ctrl.sv */
// ----------------------------------------------------------------------------
// mtdc_ctrl
// Sequencer for one item: store, step divide (skipped with one voice), tap
// walk, average divide, hand-off to the output register.
// ----------------------------------------------------------------------------
module mtdc_ctrl import mtdc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRITE,
      S_STEP_START,
      S_STEP_WAIT,
      S_TAPS,
      S_DRAIN,
      S_AVG_START,
      S_AVG_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // state and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= S_WRITE;
                  ready_ff <= 1'b0;
               end
            end
            S_WRITE: begin
               state_ff <= status.one_voice ? S_TAPS : S_STEP_START;
            end
            S_STEP_START: state_ff <= S_STEP_WAIT;
            S_STEP_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_TAPS;
               end
            end
            S_TAPS: begin
               if (status.tap_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN:     state_ff <= S_AVG_START;
            S_AVG_START: state_ff <= S_AVG_WAIT;
            S_AVG_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == S_IDLE) && req_valid && ready_ff;
      cmd.write_mem = (state_ff == S_WRITE);
      cmd.tap_init  = (state_ff == S_WRITE);
      cmd.step_zero = (state_ff == S_WRITE) && status.one_voice;
      cmd.div_start = (state_ff == S_STEP_START) || (state_ff == S_AVG_START);
      cmd.div_avg   = (state_ff == S_AVG_START) || (state_ff == S_AVG_WAIT);
      cmd.step_load = (state_ff == S_STEP_WAIT) && status.div_done;
      cmd.tap_issue = (state_ff == S_TAPS);
      cmd.out_load  = (state_ff == S_FINISH) && status.out_free;
   end

   assign req_ready = ready_ff;

endmodule

/* hdl/multi_tap_delay_chorus_core.sv */
// ----------------------------------------------------------------------------
// multi_tap_delay_chorus_core
// Averaging multi-tap delay line chorus, one signed 16-bit sample per item.
// ----------------------------------------------------------------------------
// req_if takes one sample per item, rsp_if returns one averaged sample per
// item, both valid/ready. csr_* writes the line length (index 0) or the
// voice count (index 1); either write restarts the delay line with all taps
// reading zero and the write position at zero. Write only while idle.
// Per item: store, length/(voices-1) divide, one read per voice, sum/voices
// divide, both divides on one bit-serial divider of W = 17 + log2(MAX_VOICES)
// bits (21 by default); with one voice the length divide is skipped.
// The output register lets the next item be accepted while a result waits;
// when the receiver stalls, the following result holds in the sequencer
// until the register frees.
// Reset is synchronous: length 4096 (saturated to DELAY_DEPTH), one voice,
// the delay line reads as empty and no item is pending. A fill tracker masks
// unwritten taps, so there is no clearing pass.
// ----------------------------------------------------------------------------
module multi_tap_delay_chorus_core import mtdc_pkg::*; #(
   parameter int DELAY_DEPTH = 4096,
   parameter int MAX_VOICES  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   mtdc_req_if.sink               req_if,
   mtdc_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic                req_ready;
   logic                out_valid;
   logic [SAMPLE_W-1:0] sample_out;

   // sequencer
   mtdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mtdc_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .MAX_VOICES  (MAX_VOICES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample_in  (req_if.sample_in),
      .cmd        (cmd),
      .status     (status),
      .sample_out (sample_out),
      .out_valid  (out_valid),
      .out_ready  (rsp_if.ready)
   );

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = out_valid;
   assign rsp_if.sample_out = sample_out;

endmodule

/* hdl/mtdc_checker.sv */
// ----------------------------------------------------------------------------
// mtdc_checker
// Port-level checks on the chorus core: response hand-off and item count.
// ----------------------------------------------------------------------------
module mtdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample_out
);

   logic [2:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {2'b00, req_take} - {2'b00, rsp_take};
      end
   end

   // a result waiting on the receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // and keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("response changed while stalled");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // no result without an accepted item
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an accepted item");

   // at most one item in work and one in the output register
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("too many items in flight");

endmodule

bind multi_tap_delay_chorus_core mtdc_checker u_mtdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_sample_out (rsp_if.sample_out)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_tap_delay_chorus_core. A queue-fed driver
// sends audio samples, a clocked monitor predicts each tap average from its
// own copy of the delay line and compares it with every accepted result.
// Runs a directed pass over register corner cases, then random phases with
// changing delay length and voice count and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import mtdc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DELAY_DEPTH  = 4096;
   localparam int MAX_VOICES   = 16;
   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_LIMIT  = 3000;
   localparam int SETTLE       = 12;
   localparam int END_CYCLES   = 100;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mtdc_req_if req_ch();
   mtdc_rsp_if rsp_ch();

   multi_tap_delay_chorus_core #(
      .DELAY_DEPTH(DELAY_DEPTH),
      .MAX_VOICES (MAX_VOICES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_ch),
      .rsp_if   (rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // bench state
   logic [15:0]        pending_samples[$];
   logic signed [15:0] predicted_samples[$];
   logic               req_fired = 1'b0;
   logic               idle_on = 1'b0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   int                 quiet_cycles = 0;
   int                 error_count = 0;

   // predictor copy of the block state
   logic signed [15:0]     delay_line[DELAY_DEPTH];
   int                     write_pos;
   logic [LEN_REG_W-1:0]   cfg_length;
   logic [VOICE_REG_W-1:0] cfg_voices;

   function automatic void clear_line();
      foreach (delay_line[i]) delay_line[i] = '0;
      write_pos = 0;
   endfunction

   // store one sample and return the average of the voice taps
   function automatic logic signed [15:0] chorus_average(input logic signed [15:0] smp);
      int len;
      int nvoice;
      int step;
      int pos;
      int total;
      len = int'(cfg_length);
      if (len == 0) len = 1;
      if (len > DELAY_DEPTH) len = DELAY_DEPTH;
      nvoice = int'(cfg_voices);
      if (nvoice == 0) nvoice = 1;
      if (nvoice > MAX_VOICES) nvoice = MAX_VOICES;
      write_pos = write_pos + 1;
      if (write_pos >= len) write_pos = 0;
      delay_line[write_pos] = smp;
      // a negative step walks the taps forward
      step = (nvoice > 1) ? (len / (nvoice - 1)) - 1 : 0;
      pos = write_pos;
      total = 0;
      for (int k = 0; k < nvoice; k++) begin
         total += delay_line[pos];
         pos -= step;
         if (pos < 0) pos += len;
         if (pos >= len) pos -= len;
      end
      return 16'(total / nvoice);
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 4);
      else if (r < 98) return $urandom_range(5, 24);
      else return $urandom_range(40, 150);
   endfunction

   function automatic logic [15:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'h8000;
      else if (r < 16) return 16'h7fff;
      else if (r < 36) return 16'(int'($urandom_range(0, 64)) - 32);
      else return 16'($urandom);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.sample_in <= '0;
      end else if (req_fired || !req_ch.valid) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.sample_in <= pending_samples.pop_front();
            gap_left = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor: register writes, predictions, result checks, watchdog
   always @(posedge clock) begin
      logic signed [15:0] want;
      logic               rsp_fired;
      if (reset) begin
         cfg_length = LEN_REG_W'(RESET_LENGTH);
         cfg_voices = VOICE_REG_W'(RESET_VOICES);
         clear_line();
         predicted_samples.delete();
         req_fired = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fired = req_ch.valid && req_ch.ready;
         rsp_fired = rsp_ch.valid && rsp_ch.ready;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINE_LENGTH: begin
                  cfg_length = csr_wdata[LEN_REG_W-1:0];
                  clear_line();
               end
               CSR_VOICE_COUNT: begin
                  cfg_voices = csr_wdata[VOICE_REG_W-1:0];
                  clear_line();
               end
               default: ;
            endcase
         end
         if (req_fired) predicted_samples.push_back(chorus_average(req_ch.sample_in));
         if (rsp_fired) begin
            if (predicted_samples.size() == 0) begin
               $error("sample_out: unexpected item, got %0d", rsp_ch.sample_out);
               error_count++;
            end else begin
               want = predicted_samples.pop_front();
               if (rsp_ch.sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", want, rsp_ch.sample_out);
                  error_count++;
               end
            end
         end
         if (req_fired || rsp_fired) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every queued item has been answered
   task automatic drain_line();
      @(posedge clock);
      while (pending_samples.size() > 0 || req_ch.valid || predicted_samples.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      else if (r == 1) return CSR_DATA_W'(1);
      else if (r == 2) return CSR_DATA_W'(DELAY_DEPTH);
      else if (r == 3) return CSR_DATA_W'($urandom_range(DELAY_DEPTH + 1, 8191));
      else if (r == 4) return CSR_DATA_W'($urandom);
      else if (r < 8) return CSR_DATA_W'($urandom_range(64, DELAY_DEPTH));
      else return CSR_DATA_W'($urandom_range(2, 160));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_voices();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      else if (r == 1) return CSR_DATA_W'(1);
      else if (r == 2) return CSR_DATA_W'(MAX_VOICES);
      else if (r == 3) return CSR_DATA_W'($urandom_range(MAX_VOICES + 1, 31));
      else if (r == 4) return CSR_DATA_W'($urandom);
      else return CSR_DATA_W'($urandom_range(2, MAX_VOICES));
   endfunction

   // stimulus
   initial begin
      int random_sent;
      int n;
      int unsigned kind;
      int unsigned cfg_pick;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;
      rsp_ch.ready     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, one voice: output follows input
      idle_on = 1'b1;
      pending_samples = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                          16'h5555, 16'haaaa};
      drain_line();

      // zero length reads as one entry, taps step forward over it
      csr_write(CSR_LINE_LENGTH, '0);
      csr_write(CSR_VOICE_COUNT, CSR_DATA_W'(MAX_VOICES));
      @(posedge clock);
      pending_samples = '{16'h7fff, 16'h8000, 16'h1234};
      drain_line();

      // length and voice count above their maximum saturate
      csr_write(CSR_LINE_LENGTH, 13'h1fff);
      csr_write(CSR_VOICE_COUNT, CSR_DATA_W'(31));
      @(posedge clock);
      pending_samples = '{16'h7fff, 16'h8001, 16'h0003};
      drain_line();

      // voice count zero through masked upper data bits
      csr_write(CSR_VOICE_COUNT, 13'h1fe0);
      @(posedge clock);
      pending_samples = '{16'hc000, 16'h3fff};
      drain_line();

      // length shorter than voices minus one, position wraps often
      csr_write(CSR_LINE_LENGTH, CSR_DATA_W'(5));
      csr_write(CSR_VOICE_COUNT, CSR_DATA_W'(MAX_VOICES));
      @(posedge clock);
      pending_samples = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hfffd};
      drain_line();

      // unknown register index leaves the line alone
      csr_write(CSR_INDEX_W'($urandom_range(2, 15)), 13'h1fff);
      @(posedge clock);
      pending_samples = '{16'h0007, 16'hfff9};
      drain_line();

      // random phases
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         cfg_pick = $urandom_range(0, 9);
         if (cfg_pick == 0) begin
            csr_write(CSR_INDEX_W'($urandom_range(2, 15)), CSR_DATA_W'($urandom));
         end else if (cfg_pick == 1) begin
            csr_write(CSR_LINE_LENGTH, pick_length());
         end else if (cfg_pick == 2) begin
            csr_write(CSR_VOICE_COUNT, pick_voices());
         end else begin
            csr_write(CSR_LINE_LENGTH, pick_length());
            csr_write(CSR_VOICE_COUNT, pick_voices());
         end
         idle_on = ($urandom_range(0, 4) != 0);
         kind = $urandom_range(0, 9);
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 320) : $urandom_range(10, 90);
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         @(posedge clock);
         for (int i = 0; i < n; i++) begin
            if (kind == 0) pending_samples.push_back(16'h8000);
            else if (kind == 1) pending_samples.push_back(16'h7fff);
            else if (kind == 2) pending_samples.push_back(i[0] ? 16'h7fff : 16'h8000);
            else pending_samples.push_back(pick_sample());
         end
         random_sent += n;
         drain_line();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (predicted_samples.size() != 0) begin
         $error("sample_out: %0d expected items never arrived", predicted_samples.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
